// ===== hdl/ttjf_pkg.sv =====
package ttjf_pkg;

  localparam int FINGER_SLOTS = 8;
  localparam int COORD_BITS   = 16;
  localparam int SLOT_IDX_W   = 3;

  localparam logic [11:0] TAP_DISTANCE_RST = 12'd100;
  localparam logic [15:0] TAP_TIME_RST     = 16'd150;
  localparam logic [3:0]  TAP_Y_EXTRA      = 4'd10;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TAP_DISTANCE = 1'b0,
    REG_TAP_TIME     = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_DOWN = 1'b0,
    OP_UP   = 1'b1
  } op_t;

  typedef logic [FINGER_SLOTS-1:0] slot_mask_t;
  typedef logic [COORD_BITS-1:0]   coord_t;

  typedef struct packed {
    logic                  operation;
    logic [SLOT_IDX_W-1:0] finger_index;
    logic [15:0]           pos_x;
    logic [15:0]           pos_y;
    logic [31:0]           time_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic        snapped;
    logic        filter_on;
  } out_item_t;

  typedef struct packed {
    slot_mask_t  contact_mask;
    logic        active;
    coord_t      anchor_x;
    coord_t      anchor_y;
    logic [31:0] first_touch_time;
  } filt_state_t;

  typedef struct packed {
    logic [11:0] tap_distance;
    logic [15:0] tap_time_ms;
  } filt_cfg_t;

endpackage

// ===== hdl/ttjf_step.sv =====
module ttjf_step
  import ttjf_pkg::*;
(
  input  in_item_t    item,
  input  filt_state_t state,
  input  filt_cfg_t   cfg,
  output filt_state_t state_next,
  output out_item_t   result
);

  logic             in_range;
  slot_mask_t       bit_sel;
  slot_mask_t       cur_down;
  slot_mask_t       cur_up;
  coord_t           x;
  coord_t           y;
  coord_t           dx;
  coord_t           dy;
  logic [31:0]      dt;
  logic [12:0]      y_limit;
  logic             multi;
  logic             in_time;
  logic             in_box;
  logic             snap;

  always_comb begin
    in_range = 32'(item.finger_index) < FINGER_SLOTS;
    bit_sel  = slot_mask_t'(1) << item.finger_index;
    cur_down = state.contact_mask | bit_sel;
    cur_up   = state.contact_mask & ~bit_sel;
    x        = item.pos_x[COORD_BITS-1:0];
    y        = item.pos_y[COORD_BITS-1:0];
    dx       = (state.anchor_x >= x) ? state.anchor_x - x : x - state.anchor_x;
    dy       = (state.anchor_y >= y) ? state.anchor_y - y : y - state.anchor_y;
    dt       = item.time_ms - state.first_touch_time;
    y_limit  = {1'b0, cfg.tap_distance} + 13'(TAP_Y_EXTRA);
    multi    = (cur_down & (cur_down - slot_mask_t'(1))) != '0;
    in_time  = dt < {16'b0, cfg.tap_time_ms};
    in_box   = (32'(dx) <= 32'(cfg.tap_distance)) && (32'(dy) <= 32'(y_limit));
    snap     = 1'b0;

    state_next = state;
    if (in_range) begin
      if (item.operation == OP_DOWN) begin
        if (!state.active) begin
          if (state.contact_mask == '0) begin
            state_next.anchor_x         = x;
            state_next.anchor_y         = y;
            state_next.active           = 1'b1;
            state_next.first_touch_time = item.time_ms;
          end
        end else if (multi || !in_time || !in_box) begin
          state_next.active = 1'b0;
        end else begin
          snap = 1'b1;
        end
        state_next.contact_mask = cur_down;
      end else begin
        if (state.contact_mask != '0 && cur_up == '0) begin
          state_next.active = 1'b0;
        end
        state_next.contact_mask = cur_up;
      end
    end

    result.out_x     = snap ? 16'(state.anchor_x) : 16'(x);
    result.out_y     = snap ? 16'(state.anchor_y) : 16'(y);
    result.snapped   = snap;
    result.filter_on = state_next.active;
  end

endmodule

// ===== hdl/ttjf_regs.sv =====
module ttjf_regs
  import ttjf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   load,
  input  filt_state_t            state_next,
  output filt_state_t            state,
  output filt_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_distance <= TAP_DISTANCE_RST;
      cfg.tap_time_ms  <= TAP_TIME_RST;
      state            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_TAP_DISTANCE: cfg.tap_distance <= cfg_data[11:0];
          REG_TAP_TIME:     cfg.tap_time_ms  <= cfg_data[15:0];
          default:          ;
        endcase
      end
      if (load) begin
        state <= state_next;
      end
    end
  end

endmodule

// ===== hdl/touch_tap_jitter_filter_core.sv =====
// Touchpad tap jitter filter. Each accepted request (finger down or up report)
// gives exactly one result: the reported coordinates, or the anchor of the
// first touch while a single finger stays down inside the tap box and within
// tap_time_ms. A request is evaluated in the cycle it is accepted and its
// result appears in the output register on the next cycle, so the block takes
// one request per cycle; in_ready drops only while the output register holds a
// result that out_ready does not take. Configuration is a single-cycle write
// (index 0 tap_distance, 1 tap_time_ms) and should only be done while idle.
module touch_tap_jitter_filter_core
  import ttjf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item
);

  filt_state_t state;
  filt_state_t state_next;
  filt_cfg_t   cfg;
  out_item_t   result;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  ttjf_step u_step (
    .item       (in_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  ttjf_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .load       (accept),
    .state_next (state_next),
    .state      (state),
    .cfg        (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

  // armed filter always tracks exactly one finger
  a_active_one_finger: assert property (@(posedge clk) disable iff (rst)
    state.active |-> $onehot(state.contact_mask))
    else $error("filter active without exactly one finger in contact");

  a_snap_needs_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.snapped |-> out_item.filter_on)
    else $error("snapped result with filter off");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && out_item.filter_on == state.active)
    else $error("result missing or filter flag mismatch");

  a_snap_anchor: assert property (@(posedge clk) disable iff (rst)
    accept && result.snapped |=> out_item.out_x == 16'($past(state.anchor_x)) &&
      out_item.out_y == 16'($past(state.anchor_y)))
    else $error("snapped result not at anchor");

endmodule
